>>> src/ffac_pkg.sv
// shared types, constants and codes for the first-fit allocator
`timescale 1ns / 1ps
`default_nettype none
package ffac_pkg;

  localparam int MEM_UNITS = 32;
  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = AW + 1;
  localparam int MAX_REQUEST = 15;
  localparam int MIN_REQUEST = 2;
  localparam int MAX_ID = 25;

  localparam logic [2:0] ST_PLACED    = 3'd0;
  localparam logic [2:0] ST_COMPACTED = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_ABSENT    = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;

  typedef struct packed {
    logic       operation;
    logic [4:0] process_id;
    logic [3:0] units;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] start_unit;
    logic [5:0] largest_run;
    logic [5:0] free_total;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       restart;
    logic       alloc_scan;
    logic       fill;
    logic       pack;
    logic       tail;
    logic       free_scan;
    logic       set_status;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic req_bad;
    logic id_bad;
    logic fit;
    logic scan_end;
    logic short_space;
    logic fill_end;
    logic tail_end;
    logic found;
  } sts_t;

endpackage
`default_nettype wire

>>> src/ffac_ctrl.sv
// controller state machine sequencing scan, fill, compaction and free passes
`timescale 1ns / 1ps
`default_nettype none
module ffac_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire ffac_pkg::sts_t sts,
  output ffac_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_AFILL = 3'd2;
  localparam logic [2:0] S_CPACK = 3'd3;
  localparam logic [2:0] S_CTAIL = 3'd4;
  localparam logic [2:0] S_FSCAN = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.alloc_scan = (state_r == S_ASCAN);
    cmd.fill       = (state_r == S_AFILL);
    cmd.pack       = (state_r == S_CPACK);
    cmd.tail       = (state_r == S_CTAIL);
    cmd.free_scan  = (state_r == S_FSCAN);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.is_free_op) begin
            if (sts.id_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ffac_pkg::ST_ABSENT;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FSCAN;
            end
          end else if (sts.req_bad || sts.id_bad) begin
            cmd.set_status = 1'b1;
            cmd.status     = ffac_pkg::ST_INVALID;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if (sts.fit) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffac_pkg::ST_PLACED;
          state_nxt      = S_AFILL;
        end else if (sts.scan_end) begin
          if (sts.short_space) begin
            cmd.set_status = 1'b1;
            cmd.status     = ffac_pkg::ST_NO_SPACE;
            state_nxt      = S_RESP;
          end else begin
            cmd.restart = 1'b1;
            state_nxt   = S_CPACK;
          end
        end
      end
      S_AFILL: begin
        if (sts.fill_end) begin
          state_nxt = S_RESP;
        end
      end
      S_CPACK: begin
        if (sts.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffac_pkg::ST_COMPACTED;
          state_nxt      = S_CTAIL;
        end
      end
      S_CTAIL: begin
        if (sts.tail_end) begin
          state_nxt = S_RESP;
        end
      end
      S_FSCAN: begin
        if (sts.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = sts.found ? ffac_pkg::ST_FREED : ffac_pkg::ST_ABSENT;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/ffac_dp.sv
// datapath: owner memory, scan counters, pointers and result registers
`timescale 1ns / 1ps
`default_nettype none
module ffac_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ffac_pkg::in_item_t  in_item,
  input  wire ffac_pkg::cmd_t      cmd,
  output ffac_pkg::sts_t           sts,
  output ffac_pkg::out_item_t      out_item
);

  localparam int AW = ffac_pkg::AW;
  localparam int CW = ffac_pkg::CW;
  localparam logic [AW-1:0] LAST_UNIT = AW'(ffac_pkg::MEM_UNITS - 1);

  logic [4:0]            mem_r [ffac_pkg::MEM_UNITS];
  logic [ffac_pkg::MEM_UNITS-1:0] valid_r;
  logic [4:0]            rd_data_r;
  logic                  rd_vld_r;

  ffac_pkg::in_item_t    item_r;
  logic [CW-1:0]         raddr_r;
  logic                  pv_r;
  logic [AW-1:0]         eaddr_r;
  logic [CW-1:0]         run_r;
  logic [CW-1:0]         total_r;
  logic [CW-1:0]         best_r;
  logic [AW-1:0]         fptr_r;
  logic [AW-1:0]         dst_r;
  logic [AW-1:0]         fcnt_r;
  logic                  found_r;
  logic [CW-1:0]         free_cnt_r;
  logic [2:0]            status_r;
  logic [AW-1:0]         start_r;
  logic [CW-1:0]         largest_r;

  logic [4:0]            code;
  logic [4:0]            rdata;
  logic                  is_free;
  logic [CW-1:0]         run_n;
  logic [CW-1:0]         total_n;
  logic [CW-1:0]         best_n;
  logic [CW-1:0]         req_w;
  logic                  last;
  logic                  scan_on;
  logic                  issue;
  logic                  match;
  logic [CW-1:0]         start_calc;
  logic                  tail_code;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [4:0]            wdata;

  assign code      = item_r.process_id + 5'd1;
  assign req_w     = CW'(item_r.units);
  assign rdata     = rd_vld_r ? rd_data_r : 5'd0;
  assign is_free   = (rdata == 5'd0);
  assign run_n     = run_r + CW'(is_free);
  assign total_n   = total_r + CW'(is_free);
  assign best_n    = (run_n > best_r) ? run_n : best_r;
  assign last      = pv_r && (eaddr_r == LAST_UNIT);
  assign scan_on   = cmd.alloc_scan || cmd.pack || cmd.free_scan;
  assign issue     = scan_on && !raddr_r[CW-1];
  assign match     = cmd.free_scan && pv_r && (rdata == code);
  assign start_calc = CW'(eaddr_r) + CW'(1) - run_n;
  assign tail_code = (CW'(fcnt_r) < req_w);

  always_comb begin
    sts.is_free_op  = in_item.operation;
    sts.req_bad     = (CW'(in_item.units) < CW'(ffac_pkg::MIN_REQUEST)) ||
                      (CW'(in_item.units) > CW'(ffac_pkg::MAX_REQUEST));
    sts.id_bad      = (in_item.process_id > 5'(ffac_pkg::MAX_ID));
    sts.fit         = cmd.alloc_scan && pv_r && (run_n >= req_w);
    sts.scan_end    = last;
    sts.short_space = (total_n < req_w);
    sts.fill_end    = (fcnt_r == AW'(req_w - CW'(1)));
    sts.tail_end    = (dst_r == LAST_UNIT);
    sts.found       = found_r || match;
  end

  always_comb begin
    we    = 1'b0;
    waddr = dst_r;
    wdata = 5'd0;
    if (cmd.fill) begin
      we    = 1'b1;
      waddr = fptr_r;
      wdata = code;
    end else if (cmd.pack) begin
      we    = pv_r && !is_free;
      waddr = dst_r;
      wdata = rdata;
    end else if (cmd.tail) begin
      we    = 1'b1;
      waddr = dst_r;
      wdata = tail_code ? code : 5'd0;
    end else if (cmd.free_scan) begin
      we    = match;
      waddr = eaddr_r;
      wdata = 5'd0;
    end
  end

  // owner memory, unwritten entries read as free
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (issue) begin
      rd_data_r <= mem_r[raddr_r[AW-1:0]];
      rd_vld_r  <= valid_r[raddr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r       <= 1'b0;
      free_cnt_r <= CW'(ffac_pkg::MEM_UNITS);
    end else begin
      if (cmd.load || cmd.restart) begin
        pv_r <= 1'b0;
      end else begin
        pv_r <= issue;
      end
      if (cmd.fill || (cmd.tail && tail_code)) begin
        free_cnt_r <= free_cnt_r - CW'(1);
      end else if (match) begin
        free_cnt_r <= free_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    eaddr_r <= raddr_r[AW-1:0];
    if (cmd.load) begin
      item_r    <= in_item;
      raddr_r   <= '0;
      run_r     <= '0;
      total_r   <= '0;
      best_r    <= '0;
      dst_r     <= '0;
      fcnt_r    <= '0;
      found_r   <= 1'b0;
      start_r   <= '0;
      largest_r <= '0;
    end else if (cmd.restart) begin
      raddr_r <= '0;
    end else if (issue) begin
      raddr_r <= raddr_r + CW'(1);
    end

    if (cmd.alloc_scan && pv_r) begin
      total_r <= total_n;
      if (run_n >= req_w) begin
        fptr_r  <= start_calc[AW-1:0];
        start_r <= start_calc[AW-1:0];
      end else begin
        if (!is_free || last) begin
          best_r <= best_n;
          run_r  <= '0;
        end else begin
          run_r <= run_n;
        end
        if (last && !(total_n < req_w)) begin
          start_r   <= AW'(CW'(ffac_pkg::MEM_UNITS) - total_n);
          largest_r <= best_n;
        end
      end
    end

    if (cmd.fill) begin
      fptr_r <= fptr_r + AW'(1);
      fcnt_r <= fcnt_r + AW'(1);
    end

    if (cmd.pack && pv_r && !is_free) begin
      dst_r <= dst_r + AW'(1);
    end

    if (cmd.tail) begin
      dst_r  <= dst_r + AW'(1);
      fcnt_r <= fcnt_r + AW'(1);
    end

    if (match) begin
      found_r <= 1'b1;
    end

    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  always_comb begin
    out_item.status      = status_r;
    out_item.start_unit  = start_r;
    out_item.largest_run = largest_r;
    out_item.free_total  = free_cnt_r;
  end

endmodule
`default_nettype wire

>>> src/first_fit_allocator_compaction.sv
// top level of the first-fit contiguous allocator with compaction
// Usage:
//   An item (operation, process_id, units) is taken on a rising edge with
//   start high and busy low. busy stays high until the result has gone out.
//   The result (status, start_unit, largest_run, free_total) is shown on
//   out_item for exactly one cycle, marked by out_valid; the receiver cannot
//   stall, so it must take the item in that cycle.
// Sequence (set by the sweep over the 32-entry owner memory, one unit read
// per cycle, the read data registered):
//   invalid request or free of an unknown id: straight to the result
//   free: a full sweep that clears the id's units, then the result
//   allocate placed: a sweep up to the first fitting run, then the fill of
//   the units, then the result
//   allocate no space: a full sweep, then the result
//   allocate with compaction: a full sweep, a packing sweep, then a tail
//   pass that places the item behind the packed units, then the result
// Reset: synchronous, active low; every unit reads as free afterwards at
// once, no clearing sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_allocator_compaction (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire ffac_pkg::in_item_t  in_item,
  output logic                     busy,
  output logic                     out_valid,
  output ffac_pkg::out_item_t      out_item
);

  ffac_pkg::cmd_t cmd;
  ffac_pkg::sts_t sts;

  ffac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ffac_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
